### design/sat_pkg.sv
// Shared types, constants and the descriptor check for the segment address translator.
`default_nettype none

package sat_pkg;

    // Table depths used when the top level is not overridden.
    localparam int GLOBAL_DEPTH_DEF = 256;
    localparam int LOCAL_DEPTH_DEF  = 256;

    // Field widths of the stream items.
    localparam int MODE_W = 2;
    localparam int SLOT_W = 8;
    localparam int DESC_W = 64;
    localparam int SEL_W  = 16;
    localparam int OFF_W  = 32;
    localparam int LIN_W  = 33;
    localparam int IDX_W  = 13;
    localparam int CNT_W  = 9;
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_GLOBAL = 2'd0,
        MODE_LOAD_LOCAL  = 2'd1,
        MODE_TRANSLATE   = 2'd2,
        MODE_NONE        = 2'd3
    } mode_t;

    typedef enum logic {
        REG_GLOBAL_COUNT = 1'b0,
        REG_LOCAL_COUNT  = 1'b1
    } reg_idx_t;

    localparam logic [OFF_W-1:0] TOP16 = 32'h0000_FFFF;
    localparam logic [OFF_W-1:0] TOP32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             ok;
        logic [LIN_W-1:0] lin;
    } xlat_t;

    // Decodes one descriptor and checks an offset and a requested privilege against it.
    function automatic xlat_t sat_check(input logic [DESC_W-1:0] d,
                                        input logic [1:0] rpl,
                                        input logic [OFF_W-1:0] off);
        logic [19:0]      limit;
        logic [OFF_W-1:0] base;
        logic [OFF_W-1:0] scaled;
        logic [LIN_W-1:0] lo;
        logic [LIN_W-1:0] hi;
        logic             expand_down;
        xlat_t            res;
        limit  = {d[51:48], d[15:0]};
        base   = {d[63:56], d[39:16]};
        scaled = d[55] ? {limit, 12'hFFF} : {12'd0, limit};
        expand_down = d[44] && !d[43] && d[42];
        if (expand_down) begin
            lo = {1'b0, scaled} + 33'd1;
            hi = {1'b0, (d[54] ? TOP32 : TOP16)};
        end else begin
            lo = '0;
            hi = {1'b0, scaled};
        end
        res.ok  = ({1'b0, off} >= lo) && ({1'b0, off} <= hi) && (d[46:45] >= rpl) && d[47];
        res.lin = res.ok ? ({1'b0, base} + {1'b0, off}) : '0;
        return res;
    endfunction

endpackage

`default_nettype wire

### design/sat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/segment_address_translator_core.sv
// Top level of the segment address translator: table RAMs, lookup stage and output register.
//
// Usage: the slave stream carries one item per transfer. s_tuser selects the
// operation: load a global descriptor, load a local descriptor, or translate
// a selector and offset. Load items write the addressed table RAM and give no
// result. A translate item reads its table RAM, checks the offset range,
// privilege and present bit, and gives one result transfer on the master
// stream: m_tuser holds ok, m_tdata the linear address (zero when not ok).
// A translate accepted on the slave stream reads its table RAM into the lookup
// stage, and its result is then registered in the output register for the master stream.
// Throughput: one item per cycle while the receiver takes results; the single read
// port of each table RAM and the one lookup stage set this figure.
// The counts live on the APB port (global count at 0x0, local count at 0x4);
// the user writes them only while no item is in flight, which the block does not enforce.
// Reset clears the counts and the valid flags of the lookup stage and the
// output register; table contents are undefined until loaded.
// When the receiver stalls, the result stays in the output register, one more
// translate waits in the lookup stage, and then s_tready drops.
`default_nettype none

module segment_address_translator_core #(
    parameter int GLOBAL_DEPTH = sat_pkg::GLOBAL_DEPTH_DEF,
    parameter int LOCAL_DEPTH  = sat_pkg::LOCAL_DEPTH_DEF,
    localparam int GAW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1,
    localparam int LAW = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Slave stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Low to high: entry_slot[7:0], descriptor[71:8], segment_selector[87:72],
    // offset_address[119:88].
    input  wire logic [sat_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[1:0].
    input  wire logic [sat_pkg::MODE_W-1:0]      s_tuser,
    // Master stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Low to high: linear_address[32:0], zero fill [39:33].
    output logic      [sat_pkg::M_TDATA_W-1:0]   m_tdata,
    // ok[0].
    output logic                                 m_tuser,
    // APB configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sat_pkg::APB_AW-1:0]      paddr,
    input  wire logic [sat_pkg::APB_DW-1:0]      pwdata,
    output logic      [sat_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready
);

    import sat_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0] global_count_reg;
    logic [CNT_W-1:0] local_count_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    // Input item fields.
    mode_t              in_mode;
    logic [SLOT_W-1:0]  in_slot;
    logic [DESC_W-1:0]  in_desc;
    logic [SEL_W-1:0]   in_sel;
    logic [OFF_W-1:0]   in_off;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   slot_ext;
    logic               in_local;
    logic               s_xfer;
    logic               idx_ok;

    // Lookup stage.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_local_reg;
    logic               s1_inrange_reg;
    logic [1:0]         s1_rpl_reg;
    logic [OFF_W-1:0]   s1_off_reg;
    logic               s1_adv;
    logic [DESC_W-1:0]  g_rdata;
    logic [DESC_W-1:0]  l_rdata;
    logic [DESC_W-1:0]  s1_desc;
    xlat_t              s1_res;

    // Output register.
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_ok_reg;
    logic [LIN_W-1:0]   m_lin_reg;

    // RAM controls.
    logic               g_we;
    logic               l_we;
    logic               g_re;
    logic               l_re;

    // APB write decode; pready is always high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            global_count_reg <= '0;
            local_count_reg  <= '0;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_GLOBAL_COUNT: global_count_reg <= pwdata[CNT_W-1:0];
                REG_LOCAL_COUNT:  local_count_reg  <= pwdata[CNT_W-1:0];
                default:          global_count_reg <= global_count_reg;
            endcase
        end
    end

    // APB read mux.
    always_comb begin
        case (cfg_idx)
            REG_GLOBAL_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, global_count_reg};
            REG_LOCAL_COUNT:  prdata = {{(APB_DW-CNT_W){1'b0}}, local_count_reg};
            default:          prdata = '0;
        endcase
    end

    // Unpack the slave transfer.
    assign in_mode  = mode_t'(s_tuser);
    assign in_slot  = s_tdata[7:0];
    assign in_desc  = s_tdata[71:8];
    assign in_sel   = s_tdata[87:72];
    assign in_off   = s_tdata[119:88];
    assign in_idx   = in_sel[15:3];
    assign in_local = in_sel[2];
    assign slot_ext = {{(IDX_W-SLOT_W){1'b0}}, in_slot};
    assign s_xfer   = s_tvalid && s_tready;

    // Index range check against the count, the depth and the null global selector.
    always_comb begin
        if (in_local) begin
            idx_ok = (in_idx < {{(IDX_W-CNT_W){1'b0}}, local_count_reg})
                  && ({1'b0, in_idx} < 14'(LOCAL_DEPTH));
        end else begin
            idx_ok = (in_idx != '0)
                  && (in_idx < {{(IDX_W-CNT_W){1'b0}}, global_count_reg})
                  && ({1'b0, in_idx} < 14'(GLOBAL_DEPTH));
        end
    end

    // Table RAM strobes; loads beyond the depth are dropped.
    assign g_we = s_xfer && (in_mode == MODE_LOAD_GLOBAL)
               && ({1'b0, slot_ext} < 14'(GLOBAL_DEPTH));
    assign l_we = s_xfer && (in_mode == MODE_LOAD_LOCAL)
               && ({1'b0, slot_ext} < 14'(LOCAL_DEPTH));
    assign g_re = s_xfer && (in_mode == MODE_TRANSLATE) && !in_local;
    assign l_re = s_xfer && (in_mode == MODE_TRANSLATE) && in_local;

    sat_ram #(
        .WIDTH (DESC_W),
        .DEPTH (GLOBAL_DEPTH)
    ) u_global_ram (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (slot_ext[GAW-1:0]),
        .wdata (in_desc),
        .re    (g_re),
        .raddr (in_idx[GAW-1:0]),
        .rdata (g_rdata)
    );

    sat_ram #(
        .WIDTH (DESC_W),
        .DEPTH (LOCAL_DEPTH)
    ) u_local_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (slot_ext[LAW-1:0]),
        .wdata (in_desc),
        .re    (l_re),
        .raddr (in_idx[LAW-1:0]),
        .rdata (l_rdata)
    );

    // The lookup stage moves on when the output register is free or being drained.
    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_tready) begin
            s1_valid_next = s_xfer && (in_mode == MODE_TRANSLATE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Lookup stage payload; the RAM read data holds while the stage is stalled.
    always_ff @(posedge aclk) begin
        if (s_xfer && (in_mode == MODE_TRANSLATE)) begin
            s1_local_reg   <= in_local;
            s1_inrange_reg <= idx_ok;
            s1_rpl_reg     <= in_sel[1:0];
            s1_off_reg     <= in_off;
        end
    end

    // Descriptor decode, limit and privilege checks, and the base add.
    assign s1_desc = s1_local_reg ? l_rdata : g_rdata;
    assign s1_res  = sat_check(s1_desc, s1_rpl_reg, s1_off_reg);

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_ok_reg  <= s1_inrange_reg && s1_res.ok;
            m_lin_reg <= s1_inrange_reg ? s1_res.lin : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {{(M_TDATA_W-LIN_W){1'b0}}, m_lin_reg};

    // A translate transfer always enters the lookup stage.
    a_xlat_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (in_mode == MODE_TRANSLATE) |=> s1_valid_reg)
        else $error("translate transfer did not reach the lookup stage");

    // A stalled lookup stage with a full, stalled output blocks the input.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while the lookup stage is blocked");

    // A result leaving the lookup stage lands in the output register.
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_adv |=> m_valid_reg)
        else $error("lookup result lost");

    // A rejected access carries a zero address.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> (m_lin_reg == '0))
        else $error("rejected access with nonzero address");

endmodule

`default_nettype wire

### test/segment_address_translator_core_tb.sv
// Self-checking testbench for the segment address translator core.
`timescale 1ns / 1ps

module segment_address_translator_core_tb;

    import sat_pkg::*;

    // Register addresses on the configuration port.
    localparam logic [APB_AW-1:0] ADDR_GLOBAL_COUNT = 3'h0;
    localparam logic [APB_AW-1:0] ADDR_LOCAL_COUNT  = 3'h4;

    // Segment type codes in descriptor bits 44:42 (S, X, E).
    localparam logic [2:0] TYPE_SYSTEM    = 3'b000;
    localparam logic [2:0] TYPE_DATA_UP   = 3'b100;
    localparam logic [2:0] TYPE_DATA_DOWN = 3'b101;
    localparam logic [2:0] TYPE_CODE      = 3'b110;

    localparam int TABLE_SLOTS   = 256;
    // A translate's result passes the lookup stage and the output register before it can
    // transfer; loads may still be writing a table RAM when the last result has come.
    localparam int SETTLE_CYCLES = 4;
    // Under the heaviest idling a quiet stretch stays far below this.
    localparam int QUIET_LIMIT   = 2000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Predicts each translation and checks result transfers in order.
    class xlat_scoreboard;
        logic [DESC_W-1:0] gdt_entry [TABLE_SLOTS];
        logic [DESC_W-1:0] ldt_entry [TABLE_SLOTS];
        logic [CNT_W-1:0]  gdt_count;
        logic [CNT_W-1:0]  ldt_count;
        xlat_t             pending_q [$];
        int                errors;
        int                loads;
        int                translations;
        int                valid_hits;
        int                unused_items;

        function new();
            gdt_count    = '0;
            ldt_count    = '0;
            errors       = 0;
            loads        = 0;
            translations = 0;
            valid_hits   = 0;
            unused_items = 0;
        endfunction

        // Range, privilege and present checks for one descriptor.
        function xlat_t resolve_descriptor(logic [DESC_W-1:0] d, logic [1:0] rpl,
                                           logic [OFF_W-1:0] off);
            logic [19:0]      lim;
            logic [LIN_W-1:0] base;
            logic [LIN_W-1:0] scaled;
            logic [LIN_W-1:0] lo;
            logic [LIN_W-1:0] hi;
            logic [LIN_W-1:0] wide_off;
            xlat_t            r;
            lim      = {d[51:48], d[15:0]};
            base     = {1'b0, d[63:56], d[39:16]};
            scaled   = d[55] ? {1'b0, lim, 12'hFFF} : {13'd0, lim};
            wide_off = {1'b0, off};
            // Expand-down data segments keep the range above the limit; the lower
            // bound is taken in 33 bits, so a full limit leaves nothing valid.
            if (d[44] && !d[43] && d[42]) begin
                lo = scaled + 33'd1;
                hi = d[54] ? 33'h0_FFFF_FFFF : 33'h0_0000_FFFF;
            end else begin
                lo = '0;
                hi = scaled;
            end
            r.ok  = (wide_off >= lo) && (wide_off <= hi) && (d[46:45] >= rpl) && d[47];
            r.lin = r.ok ? base + wide_off : '0;
            return r;
        endfunction

        function void note_count(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
            if (addr == ADDR_GLOBAL_COUNT) begin
                gdt_count = data[CNT_W-1:0];
            end else if (addr == ADDR_LOCAL_COUNT) begin
                ldt_count = data[CNT_W-1:0];
            end
        endfunction

        function void note_item(mode_t mode, logic [S_TDATA_W-1:0] data);
            logic [SLOT_W-1:0] slot;
            logic [DESC_W-1:0] desc;
            logic [SEL_W-1:0]  sel;
            logic [OFF_W-1:0]  off;
            logic [IDX_W-1:0]  idx;
            xlat_t             res;
            slot = data[7:0];
            desc = data[71:8];
            sel  = data[87:72];
            off  = data[119:88];
            idx  = sel[15:3];
            res  = '0;
            case (mode)
                MODE_LOAD_GLOBAL: begin
                    gdt_entry[slot] = desc;
                    loads++;
                end
                MODE_LOAD_LOCAL: begin
                    ldt_entry[slot] = desc;
                    loads++;
                end
                MODE_TRANSLATE: begin
                    // Bit 2 of the selector picks the local table; global index 0 is null.
                    if (sel[2]) begin
                        if (idx < ldt_count && idx < TABLE_SLOTS)
                            res = resolve_descriptor(ldt_entry[idx[7:0]], sel[1:0], off);
                    end else begin
                        if (idx != 0 && idx < gdt_count && idx < TABLE_SLOTS)
                            res = resolve_descriptor(gdt_entry[idx[7:0]], sel[1:0], off);
                    end
                    pending_q.push_back(res);
                    translations++;
                    if (res.ok)
                        valid_hits++;
                end
                default: begin
                    unused_items++;
                end
            endcase
        endfunction

        function void check_result(logic ok, logic [M_TDATA_W-1:0] data);
            xlat_t want;
            if (pending_q.size() == 0) begin
                $error("result with no translation outstanding: ok=%0d linear_address=0x%0h",
                       ok, data[LIN_W-1:0]);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (want.ok !== ok) begin
                    $error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
                    errors++;
                end
                if (want.lin !== data[LIN_W-1:0]) begin
                    $error("linear_address mismatch: expected 0x%0h, actual 0x%0h",
                           want.lin, data[LIN_W-1:0]);
                    errors++;
                end
            end
        endfunction
    endclass

    xlat_scoreboard sb;

    // Stimulus-side copy of what has been loaded and configured.
    logic [DESC_W-1:0] shadow_gdt [TABLE_SLOTS];
    logic [DESC_W-1:0] shadow_ldt [TABLE_SLOTS];
    bit                loaded_gdt [TABLE_SLOTS];
    bit                loaded_ldt [TABLE_SLOTS];
    int unsigned       cur_gc;
    int unsigned       cur_lc;
    int unsigned       sender_idle_pct;
    int unsigned       stall_pct;
    int                quiet_cycles;

    segment_address_translator_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Observe transfers on all three ports.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready)
                sb.note_count(paddr, pwdata);
            if (s_tvalid && s_tready)
                sb.note_item(mode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("segment_address_translator_core regression: fail");
            $finish;
        end
    end

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_counts(input int unsigned gc, input int unsigned lc);
        apb_write(ADDR_GLOBAL_COUNT, gc);
        apb_write(ADDR_LOCAL_COUNT, lc);
        cur_gc = gc;
        cur_lc = lc;
    endtask

    // Holds the sender until every outstanding translation has answered.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(input mode_t mode, input logic [SLOT_W-1:0] slot,
                             input logic [DESC_W-1:0] desc, input logic [SEL_W-1:0] sel,
                             input logic [OFF_W-1:0] off);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {off, sel, desc, slot};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic load_entry(input bit to_ldt, input int unsigned slot,
                              input logic [DESC_W-1:0] d);
        if (to_ldt) begin
            shadow_ldt[slot] = d;
            loaded_ldt[slot] = 1'b1;
            send_item(MODE_LOAD_LOCAL, SLOT_W'(slot), d, SEL_W'($urandom), $urandom);
        end else begin
            shadow_gdt[slot] = d;
            loaded_gdt[slot] = 1'b1;
            send_item(MODE_LOAD_GLOBAL, SLOT_W'(slot), d, SEL_W'($urandom), $urandom);
        end
    endtask

    task automatic translate(input logic [SEL_W-1:0] sel, input logic [OFF_W-1:0] off);
        send_item(MODE_TRANSLATE, SLOT_W'($urandom), {$urandom, $urandom}, sel, off);
    endtask

    function automatic logic [SEL_W-1:0] selector(input int unsigned idx, input bit to_ldt,
                                                  input logic [1:0] rpl);
        return {idx[12:0], to_ldt, rpl};
    endfunction

    function automatic logic [DESC_W-1:0] make_desc(input logic [31:0] base,
                                                    input logic [19:0] lim, input bit g,
                                                    input bit db, input bit p,
                                                    input logic [1:0] dpl,
                                                    input logic [2:0] kind);
        return {base[31:24], g, db, 2'b00, lim[19:16], p, dpl, kind, 2'b00, base[23:0],
                lim[15:0]};
    endfunction

    // Random descriptor biased toward present segments of the interesting kinds.
    function automatic logic [DESC_W-1:0] random_descriptor();
        logic [DESC_W-1:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(4))
            0: d[44:42] = TYPE_DATA_DOWN;
            1: d[44:42] = TYPE_DATA_UP;
            2: d[44:42] = TYPE_CODE;
            default: ;
        endcase
        if ($urandom_range(9) < 8)
            d[47] = 1'b1;
        if ($urandom_range(3) == 0) begin
            d[51:48] = 4'h0;
            d[15:0]  = 16'($urandom_range(16'h0FFF));
        end
        return d;
    endfunction

    // Offsets cluster around the segment limit and the 16- and 32-bit tops.
    function automatic logic [OFF_W-1:0] pick_offset(input logic [DESC_W-1:0] d);
        logic [OFF_W-1:0] edge_off;
        edge_off = d[55] ? {d[51:48], d[15:0], 12'hFFF} : {12'd0, d[51:48], d[15:0]};
        case ($urandom_range(8))
            0: return edge_off;
            1: return edge_off + 32'd1;
            2: return edge_off - 32'd1;
            3: return 32'h0000_FFFF;
            4: return 32'h0001_0000;
            5: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            6: return $urandom_range(edge_off);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DESC_W-1:0] shadow_entry(input bit to_ldt, input int unsigned idx);
        if (idx >= TABLE_SLOTS)
            return '0;
        if (to_ldt)
            return loaded_ldt[idx] ? shadow_ldt[idx] : '0;
        return loaded_gdt[idx] ? shadow_gdt[idx] : '0;
    endfunction

    // True when a translate with this selector would fetch a never-loaded entry.
    function automatic bit reads_unloaded(input logic [SEL_W-1:0] sel);
        int unsigned idx;
        idx = 32'(sel[15:3]);
        if (idx >= TABLE_SLOTS)
            return 1'b0;
        if (sel[2])
            return idx < cur_lc && !loaded_ldt[idx];
        return idx != 0 && idx < cur_gc && !loaded_gdt[idx];
    endfunction

    task automatic random_item();
        int unsigned       roll;
        int unsigned       span;
        int unsigned       lowest;
        int unsigned       idx;
        int unsigned       tries;
        bit                to_ldt;
        logic [1:0]        rpl;
        logic [SEL_W-1:0]  sel;
        logic [DESC_W-1:0] d;
        roll   = $urandom_range(99);
        to_ldt = 1'($urandom_range(1));
        span   = to_ldt ? cur_lc : cur_gc;
        if (span > TABLE_SLOTS)
            span = TABLE_SLOTS;
        if (roll < 14) begin
            // Load, mostly into slots the current count makes reachable.
            if (span > 0 && $urandom_range(1))
                idx = $urandom_range(span - 1);
            else
                idx = $urandom_range(TABLE_SLOTS - 1);
            load_entry(to_ldt, idx, random_descriptor());
        end else if (roll < 17) begin
            send_item(MODE_NONE, SLOT_W'($urandom), {$urandom, $urandom}, SEL_W'($urandom),
                      $urandom);
        end else begin
            if (roll < 25) begin
                sel = SEL_W'($urandom);
            end else begin
                // Well-formed translate through a loaded entry when one is reachable.
                lowest = to_ldt ? 0 : 1;
                if (span > lowest) begin
                    idx = $urandom_range(span - 1, lowest);
                    for (tries = 0; tries < 4 && !(to_ldt ? loaded_ldt[idx] : loaded_gdt[idx]);
                         tries++)
                        idx = $urandom_range(span - 1, lowest);
                end else begin
                    idx = span + $urandom_range(15);
                end
                d = shadow_entry(to_ldt, idx);
                rpl = ($urandom_range(3) != 0) ? 2'($urandom_range(d[46:45]))
                                               : 2'($urandom_range(3));
                sel = selector(idx, to_ldt, rpl);
            end
            if (reads_unloaded(sel))
                load_entry(sel[2], 32'(sel[10:3]), random_descriptor());
            else
                translate(sel, pick_offset(shadow_entry(sel[2], 32'(sel[15:3]))));
        end
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int unsigned gc, input int unsigned lc, input int n);
        drain_results();
        set_counts(gc, lc);
        sender_idle_pct = idle;
        stall_pct       = stall;
        for (int i = 0; i < n; i++) begin
            random_item();
            if (i == n / 2)
                drain_results();
        end
    endtask

    task automatic directed_items();
        logic [DESC_W-1:0] d;
        // Flat code segment at the top base: largest linear address, not wrapped.
        d = make_desc(32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 2'd3, TYPE_CODE);
        load_entry(1'b0, 1, d);
        translate(selector(1, 1'b0, 2'd3), 32'h0000_0000);
        translate(selector(1, 1'b0, 2'd0), 32'hFFFF_FFFF);
        // Byte-granular data segment: limit edge and a privilege fault.
        d = make_desc(32'h0001_0000, 20'h00FFF, 1'b0, 1'b0, 1'b1, 2'd0, TYPE_DATA_UP);
        load_entry(1'b0, 2, d);
        translate(selector(2, 1'b0, 2'd0), 32'h0000_0FFF);
        translate(selector(2, 1'b0, 2'd0), 32'h0000_1000);
        translate(selector(2, 1'b0, 2'd1), 32'h0000_0000);
        // Segment not present.
        d = make_desc(32'h0000_0100, 20'hFFFFF, 1'b1, 1'b1, 1'b0, 2'd3, TYPE_DATA_UP);
        load_entry(1'b0, 5, d);
        translate(selector(5, 1'b0, 2'd0), 32'h0000_0000);
        // Expand-down with a 16-bit top, through local index 0.
        d = make_desc(32'h2000_0000, 20'h00FFF, 1'b0, 1'b0, 1'b1, 2'd3, TYPE_DATA_DOWN);
        load_entry(1'b1, 0, d);
        translate(selector(0, 1'b1, 2'd3), 32'h0000_0FFF);
        translate(selector(0, 1'b1, 2'd3), 32'h0000_1000);
        translate(selector(0, 1'b1, 2'd3), 32'h0000_FFFF);
        translate(selector(0, 1'b1, 2'd3), 32'h0001_0000);
        // Empty expand-down segments: full 32-bit limit, and 16-bit top at its limit.
        d = make_desc(32'h0000_0000, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 2'd0, TYPE_DATA_DOWN);
        load_entry(1'b1, 3, d);
        translate(selector(3, 1'b1, 2'd0), 32'hFFFF_FFFF);
        d = make_desc(32'h0000_0000, 20'h0FFFF, 1'b0, 1'b0, 1'b1, 2'd0, TYPE_DATA_DOWN);
        load_entry(1'b1, 4, d);
        translate(selector(4, 1'b1, 2'd0), 32'h0000_FFFF);
        // Null global selector, and indexes at the table counts.
        translate(selector(0, 1'b0, 2'd0), 32'h0000_0000);
        translate(selector(cur_gc, 1'b0, 2'd0), 32'h0000_0000);
        translate(selector(cur_lc, 1'b1, 2'd0), 32'h0000_0000);
        // Extreme slots and descriptors; an all-zero descriptor is never valid.
        load_entry(1'b0, 255, {DESC_W{1'b1}});
        load_entry(1'b1, 7, {DESC_W{1'b0}});
        translate(selector(7, 1'b1, 2'd0), 32'h0000_0000);
        // Unused mode gives no result.
        send_item(MODE_NONE, 8'hFF, {DESC_W{1'b1}}, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // Main sequence: reset, directed checks, then random phases.
    initial begin
        sb              = new();
        quiet_cycles    = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        cur_gc          = 0;
        cur_lc          = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_LOAD_GLOBAL;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_counts(16, 8);
        directed_items();

        run_phase(0, 0, 256, 256, 300);
        run_phase(63, 0, 1, 255, 300);
        run_phase(0, 63, 255, 1, 300);
        run_phase(9, 9, $urandom_range(256, 2), $urandom_range(256), 300);
        run_phase(0, 0, 0, 0, 130);
        run_phase(63, 63, 256, 256, 300);
        drain_results();

        $display("Covered %0d loads, %0d translations (%0d valid), %0d unused-mode items",
                 sb.loads, sb.translations, sb.valid_hits, sb.unused_items);
        $display("over seven count settings with idle and stall rates from 0 to 63 percent.");
        if (sb.errors == 0)
            $display("segment_address_translator_core regression: pass");
        else
            $display("segment_address_translator_core regression: fail");
        $finish;
    end

endmodule
